>>> hw/rtl/set_assoc_lru_data_cache_defines.svh
// Assertion macros for the set-associative data cache.
// Included by the top level; depends on nothing else.
`ifndef SET_ASSOC_LRU_DATA_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_DATA_CACHE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SADC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SADC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SADC_ASSERT_IMP(lbl, ante, cons, msg)
`define SADC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/sadc_pkg.sv
// Shared constants, request and result types and control structs of the data cache.
// Used by sadc_ctrl, sadc_dpath and set_assoc_lru_data_cache.
package sadc_pkg;
	localparam int SET_COUNT      = 16;
	localparam int WAY_COUNT      = 16;
	localparam int WORDS_PER_LINE = 32;
	localparam int MEMORY_WORDS   = 262144;
	localparam int ADDR_W         = 20;
	localparam int DATA_W         = 32;
	localparam int STAMP_W        = 32;
	localparam int OFFS_W         = $clog2(WORDS_PER_LINE);
	localparam int SET_W          = $clog2(SET_COUNT);
	localparam int WAY_W          = $clog2(WAY_COUNT);
	localparam int WORD_W         = ADDR_W - 2;
	localparam int TAG_W          = WORD_W - OFFS_W - SET_W;
	localparam int MEM_AW         = $clog2(MEMORY_WORDS);
	localparam int LINE_AW        = SET_W + WAY_W + OFFS_W;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic                     command;
		logic [ADDR_W-1:0]        address;
		logic signed [DATA_W-1:0] write_data;
	} sadc_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic                     was_hit;
	} sadc_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic latch;
		logic lookup;
		logic compare;
		logic act;
		logic scan_step;
		logic fill_step;
	} sadc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic is_write;
		logic hit;
		logic scan_last;
		logic fill_last;
	} sadc_stat_t;
endpackage

>>> hw/rtl/sadc_ctrl.sv
// Controller state machine of the data cache.
// Depends on sadc_pkg; drives the datapath through sadc_cmd_t.
module sadc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sadc_pkg::sadc_stat_t stat,
	output sadc_pkg::sadc_cmd_t  cmd,
	output logic                busy,
	output logic                done
);
	import sadc_pkg::*;

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_LOOK = 8'b0000_0100,
		S_CMP  = 8'b0000_1000,
		S_ACT  = 8'b0001_0000,
		S_SCAN = 8'b0010_0000,
		S_FILL = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;

	// State register; reset starts the memory clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_nxt  = S_CMP;
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				if (!stat.is_write && !stat.hit) state_nxt = S_SCAN;
				else state_nxt = S_ACT;
			end
			S_ACT: begin
				cmd.act   = 1'b1;
				state_nxt = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_nxt = S_FILL;
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) state_nxt = S_DONE;
			end
			S_DONE: begin
				done      = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end
endmodule

>>> hw/rtl/sadc_dpath.sv
// Datapath of the data cache: tag, stamp, line and backing memories, victim scan, fill.
// Depends on sadc_pkg; commanded by sadc_ctrl.
module sadc_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sadc_pkg::sadc_cmd_t  cmd,
	input  sadc_pkg::sadc_req_t  request,
	output sadc_pkg::sadc_stat_t stat,
	output sadc_pkg::sadc_rsp_t  result
);
	import sadc_pkg::*;

	// Memories: rows of tags and stamps per set, line words, backing words.
	logic [WAY_COUNT-1:0][TAG_W-1:0]   tag_mem   [SET_COUNT];
	logic [WAY_COUNT-1:0][STAMP_W-1:0] stamp_mem [SET_COUNT];
	logic [DATA_W-1:0]                 line_mem  [2**LINE_AW];
	logic [DATA_W-1:0]                 bk_mem    [MEMORY_WORDS];

	sadc_req_t                         req_q;
	logic [SET_COUNT-1:0][WAY_COUNT-1:0] valid_q;
	logic [WAY_COUNT-1:0][TAG_W-1:0]   tag_row_q;
	logic [WAY_COUNT-1:0][STAMP_W-1:0] stamp_row_q;
	logic [DATA_W-1:0]                 line_rd_q;
	logic [DATA_W-1:0]                 bk_rd_q;
	logic [DATA_W-1:0]                 miss_word_q;
	logic                              hit_q;
	logic [WAY_W-1:0]                  way_q;
	logic [WAY_W-1:0]                  vic_q;
	logic [STAMP_W-1:0]                vic_stamp_q;
	logic                              found_q;
	logic [WAY_W-1:0]                  sc_q;
	logic [OFFS_W:0]                   fc_q;
	logic [MEM_AW-1:0]                 clr_q;
	logic [STAMP_W-1:0]                clk_cnt_q;

	logic [WORD_W-1:0]  word;
	logic [OFFS_W-1:0]  offs;
	logic [SET_W-1:0]   set_idx;
	logic [TAG_W-1:0]   tag;
	logic               is_write;
	logic               hit;
	logic [WAY_W-1:0]   hit_way;
	logic               fill_last;
	logic [OFFS_W-1:0]  fill_prev;
	logic               stamp_we;
	logic [WAY_W-1:0]   stamp_way;
	logic [WAY_COUNT-1:0][STAMP_W-1:0] stamp_row_new;
	logic [WAY_COUNT-1:0][TAG_W-1:0]   tag_row_new;
	logic               bk_we;
	logic [MEM_AW-1:0]  bk_waddr;
	logic [DATA_W-1:0]  bk_wdata;
	logic [MEM_AW-1:0]  bk_raddr;
	logic               line_we;
	logic [LINE_AW-1:0] line_waddr;
	logic [DATA_W-1:0]  line_wdata;

	// Address fields of the held request.
	assign word      = req_q.address[ADDR_W-1:2];
	assign offs      = word[OFFS_W-1:0];
	assign set_idx   = word[OFFS_W +: SET_W];
	assign tag       = word[OFFS_W+SET_W +: TAG_W];
	assign is_write  = (req_q.command == CMD_WRITE);
	assign fill_last = (fc_q == (OFFS_W+1)'(WORDS_PER_LINE));
	assign fill_prev = OFFS_W'(fc_q[OFFS_W-1:0] - 1'b1);

	// Tag compare across the set; the lowest matching way wins.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (valid_q[set_idx][w] && tag_row_q[w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// Stamp and tag rows with one way replaced.
	always_comb begin
		stamp_we  = (cmd.act && hit_q) || (cmd.fill_step && fill_last);
		stamp_way = cmd.fill_step ? vic_q : way_q;
		stamp_row_new = stamp_row_q;
		stamp_row_new[stamp_way] = clk_cnt_q;
		tag_row_new = tag_row_q;
		tag_row_new[vic_q] = tag;
	end

	// Backing memory port selection.
	always_comb begin
		bk_we    = 1'b0;
		bk_waddr = word[MEM_AW-1:0];
		bk_wdata = req_q.write_data;
		bk_raddr = word[MEM_AW-1:0];
		if (cmd.clr_step) begin
			bk_we    = 1'b1;
			bk_waddr = clr_q;
			bk_wdata = '0;
		end else if (cmd.act && is_write) begin
			bk_we = 1'b1;
		end
		if (cmd.fill_step) begin
			bk_raddr = MEM_AW'({tag, set_idx, fc_q[OFFS_W-1:0]});
		end
	end

	// Line memory write port: write hits and fill words.
	always_comb begin
		line_we    = 1'b0;
		line_waddr = {set_idx, way_q, offs};
		line_wdata = req_q.write_data;
		if (cmd.act && is_write && hit_q) begin
			line_we = 1'b1;
		end else if (cmd.fill_step && fc_q != '0) begin
			line_we    = 1'b1;
			line_waddr = {set_idx, vic_q, fill_prev};
			line_wdata = bk_rd_q;
		end
	end

	// Memories, written and read with registered read data.
	always_ff @(posedge clk) begin
		if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
		bk_rd_q <= bk_mem[bk_raddr];
		if (line_we) line_mem[line_waddr] <= line_wdata;
		if (cmd.act) line_rd_q <= line_mem[{set_idx, way_q, offs}];
		if (stamp_we) stamp_mem[set_idx] <= stamp_row_new;
		if (cmd.fill_step && fill_last) tag_mem[set_idx] <= tag_row_new;
		if (cmd.lookup) begin
			tag_row_q   <= tag_mem[set_idx];
			stamp_row_q <= stamp_mem[set_idx];
		end
	end

	// Request hold, compare outcome and victim scan registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= request;
		if (cmd.compare) begin
			hit_q       <= hit;
			way_q       <= hit_way;
			miss_word_q <= bk_rd_q;
		end
		if (cmd.scan_step) begin
			if (sc_q == '0) begin
				vic_q       <= '0;
				found_q     <= !valid_q[set_idx][0];
				vic_stamp_q <= stamp_row_q[0];
			end else if (!found_q) begin
				if (!valid_q[set_idx][sc_q]) begin
					vic_q   <= sc_q;
					found_q <= 1'b1;
				end else if (stamp_row_q[sc_q] < vic_stamp_q) begin
					vic_q       <= sc_q;
					vic_stamp_q <= stamp_row_q[sc_q];
				end
			end
		end
	end

	// Control counters, valid bits and the access clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			sc_q      <= '0;
			fc_q      <= '0;
			clr_q     <= '0;
			clk_cnt_q <= STAMP_W'(1);
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.compare) begin
				sc_q <= '0;
				fc_q <= '0;
			end
			if (cmd.scan_step) sc_q <= sc_q + 1'b1;
			if (cmd.fill_step) fc_q <= fc_q + 1'b1;
			if (cmd.fill_step && fill_last) valid_q[set_idx][vic_q] <= 1'b1;
			if (stamp_we) clk_cnt_q <= clk_cnt_q + 1'b1;
		end
	end

	// Status and result.
	always_comb begin
		stat.clr_last  = (clr_q == MEM_AW'(MEMORY_WORDS - 1));
		stat.is_write  = is_write;
		stat.hit       = hit;
		stat.scan_last = (sc_q == WAY_W'(WAY_COUNT - 1));
		stat.fill_last = fill_last;
		result.was_hit = hit_q;
		if (is_write) result.read_data = '0;
		else if (hit_q) result.read_data = line_rd_q;
		else result.read_data = miss_word_q;
	end
endmodule

>>> hw/rtl/set_assoc_lru_data_cache.sv
// Read hit, write hit and write miss: from accepted start the request passes the lookup, compare and act
// states to done, then returns to idle. Read miss: the compare is followed by the victim scan over the ways
// and the line fill through the single backing memory port, then done.
// One request at a time; busy is high from acceptance until the result strobe.
// After reset the backing memory is cleared one word a cycle, all 262144 words, with busy high.
// Each result is shown for one cycle on done; the receiver cannot hold it off.
module set_assoc_lru_data_cache (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sadc_pkg::sadc_req_t request,
	output logic                busy,
	output logic                done,
	output sadc_pkg::sadc_rsp_t result
);
	import sadc_pkg::*;
	`include "set_assoc_lru_data_cache_defines.svh"

	sadc_cmd_t  cmd;
	sadc_stat_t stat;

	// Controller and datapath.
	sadc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sadc_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.stat    (stat),
		.result  (result)
	);

	// Checks on the request flow.
	`SADC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`SADC_ASSERT_NXT(a_one_result, done, !done && !busy, "result strobe not followed by idle")
	`SADC_ASSERT_IMP(a_done_busy, !busy, !done, "result strobe while idle")
	`SADC_ASSERT_IMP(a_latch_idle, cmd.latch, !busy && start, "request latched outside acceptance")
endmodule
